@@ hw/rtl/ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants, control word layout and microcode for the page walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int PROCESSES   = 16;
   localparam int FRAMES      = 256;
   localparam int ENTRIES     = 8;
   localparam int PAGES       = 64;

   localparam int PROC_W      = 4;
   localparam int PAGE_W      = 6;
   localparam int COUNT_W     = 5;
   localparam int FRAME_W     = $clog2(FRAMES);
   localparam int IDX_W       = $clog2(ENTRIES);
   localparam int CURSOR_W    = FRAME_W + 1;
   localparam int REFS_W      = 8;
   localparam int STAT_W      = 16;
   localparam int STORE_DEPTH = FRAMES * ENTRIES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ENTRY_W     = 1 + FRAME_W + REFS_W;

   // result status codes
   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_OOM = 2'd1;
   localparam logic [1:0] STATUS_BAD = 2'd2;

   // sequencer steps
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] ST_CLEAR = 3'd0;
   localparam logic [STEP_W-1:0] ST_IDLE  = 3'd1;
   localparam logic [STEP_W-1:0] ST_WALK1 = 3'd2;
   localparam logic [STEP_W-1:0] ST_RD2   = 3'd3;
   localparam logic [STEP_W-1:0] ST_WALK2 = 3'd4;
   localparam logic [STEP_W-1:0] ST_EMIT  = 3'd5;

   // jump conditions
   localparam logic [2:0] COND_NEVER      = 3'd0;
   localparam logic [2:0] COND_CLEAR_DONE = 3'd1;
   localparam logic [2:0] COND_REQ        = 3'd2;
   localparam logic [2:0] COND_STOP       = 3'd3;
   localparam logic [2:0] COND_FAULT      = 3'd4;
   localparam logic [2:0] COND_OUT_FREE   = 3'd5;

   // store read address source
   localparam logic [1:0] RD_REQ   = 2'd0;
   localparam logic [1:0] RD_ENTRY = 2'd1;
   localparam logic [1:0] RD_TABLE = 2'd2;

   // datapath operations
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_CLEAR  = 3'd1;
   localparam logic [2:0] OP_LEVEL1 = 3'd2;
   localparam logic [2:0] OP_LEVEL2 = 3'd3;
   localparam logic [2:0] OP_EMIT   = 3'd4;

   typedef struct packed {
      logic              req_ready;
      logic [1:0]        rd_sel;
      logic [2:0]        op;
      logic [2:0]        cond_a;
      logic [STEP_W-1:0] target_a;
      logic [2:0]        cond_b;
      logic [STEP_W-1:0] target_b;
      logic [STEP_W-1:0] next_step;
   } useq_word_type;

   typedef struct packed {
      logic clear_done;
      logic stop;
      logic fault;
      logic out_free;
   } walk_flags_type;

   // microcode store: one control word per step
   function automatic useq_word_type useq_rom(input logic [STEP_W-1:0] step);
      useq_word_type w;
      w           = '0;
      w.rd_sel    = RD_REQ;
      w.op        = OP_NONE;
      w.cond_a    = COND_NEVER;
      w.cond_b    = COND_NEVER;
      w.target_a  = ST_IDLE;
      w.target_b  = ST_IDLE;
      w.next_step = ST_IDLE;
      unique case (step)
         ST_CLEAR: begin
            w.op        = OP_CLEAR;
            w.cond_a    = COND_CLEAR_DONE;
            w.target_a  = ST_IDLE;
            w.next_step = ST_CLEAR;
         end
         ST_IDLE: begin
            w.req_ready = 1'b1;
            w.rd_sel    = RD_REQ;
            w.cond_a    = COND_REQ;
            w.target_a  = ST_WALK1;
            w.next_step = ST_IDLE;
         end
         ST_WALK1: begin
            w.op        = OP_LEVEL1;
            w.rd_sel    = RD_ENTRY;
            w.cond_a    = COND_STOP;
            w.target_a  = ST_EMIT;
            w.cond_b    = COND_FAULT;
            w.target_b  = ST_RD2;
            w.next_step = ST_WALK2;
         end
         ST_RD2: begin
            w.rd_sel    = RD_TABLE;
            w.next_step = ST_WALK2;
         end
         ST_WALK2: begin
            w.op        = OP_LEVEL2;
            w.next_step = ST_EMIT;
         end
         ST_EMIT: begin
            w.op        = OP_EMIT;
            w.cond_a    = COND_OUT_FREE;
            w.target_a  = ST_IDLE;
            w.next_step = ST_EMIT;
         end
         default: begin
            w.next_step = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/two_level_page_walk_demand_alloc.sv @@
// ----------------------------------------------------------------------------
// two_level_page_walk_demand_alloc
// Two-level page table walk with on-demand frame allocation.
// ----------------------------------------------------------------------------
//  port group  direction  handshake            payload
//  req_*       in         req_valid/req_ready  process_index, virtual_page
//  rsp_*       out        rsp_valid/rsp_ready  status .. process_refs
//  csr_*       in         csr_wr_en            process_count
//
//  After acceptance a walk runs WALK1, then WALK2 and EMIT; a faulting
//  first-level entry adds RD2 before WALK2: the entry store has one read
//  and one write port, and the first-level write must land before the
//  second-level read. A walk that stops at the first level (halted, bad
//  index, no frame left) goes from WALK1 straight to EMIT. The next request
//  is taken in the IDLE step that follows the load of the response.
//  After reset the store is swept clear, one entry per cycle, with req_ready
//  low. A waiting result holds in the output register while
//  the next request is taken; the walker stalls only if it is still held.
// ----------------------------------------------------------------------------
module two_level_page_walk_demand_alloc (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ptw_pkg::PROC_W-1:0]   req_process_index,
   input  logic [ptw_pkg::PAGE_W-1:0]   req_virtual_page,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [1:0]                   rsp_faults,
   output logic [ptw_pkg::FRAME_W-1:0]  rsp_table_frame,
   output logic [ptw_pkg::FRAME_W-1:0]  rsp_data_frame,
   output logic [ptw_pkg::REFS_W-1:0]   rsp_entry_refs,
   output logic [ptw_pkg::CURSOR_W-1:0] rsp_process_frames,
   output logic [ptw_pkg::STAT_W-1:0]   rsp_process_faults,
   output logic [ptw_pkg::STAT_W-1:0]   rsp_process_refs,
   input  logic                         csr_wr_en,
   input  logic [ptw_pkg::COUNT_W-1:0]  csr_wr_data
);
   import ptw_pkg::*;

   useq_word_type       ctrl;
   walk_flags_type      flags;
   logic [ENTRY_W-1:0]  rd_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0]  wr_data;

   assign req_ready = ctrl.req_ready;

   ptw_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .flags     (flags),
      .ctrl      (ctrl)
   );

   ptw_walk u_walk (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .flags              (flags),
      .req_valid          (req_valid),
      .req_process_index  (req_process_index),
      .req_virtual_page   (req_virtual_page),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rd_data            (rd_data),
      .rd_addr            (rd_addr),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_faults         (rsp_faults),
      .rsp_table_frame    (rsp_table_frame),
      .rsp_data_frame     (rsp_data_frame),
      .rsp_entry_refs     (rsp_entry_refs),
      .rsp_process_frames (rsp_process_frames),
      .rsp_process_faults (rsp_process_faults),
      .rsp_process_refs   (rsp_process_refs)
   );

   ptw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

@@ hw/rtl/ptw_ram.sv @@
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptw_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ptw_useq.sv @@
// ----------------------------------------------------------------------------
// ptw_useq
// Step counter and jump logic; fetches one control word per step.
// ----------------------------------------------------------------------------
module ptw_useq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  ptw_pkg::walk_flags_type flags,
   output ptw_pkg::useq_word_type  ctrl
);
   import ptw_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              hit_a;
   logic              hit_b;

   function automatic logic cond_hit(input logic [2:0] code, input logic req,
                                     input walk_flags_type f);
      logic hit;
      hit = 1'b0;
      case (code)
         COND_NEVER:      hit = 1'b0;
         COND_CLEAR_DONE: hit = f.clear_done;
         COND_REQ:        hit = req;
         COND_STOP:       hit = f.stop;
         COND_FAULT:      hit = f.fault;
         COND_OUT_FREE:   hit = f.out_free;
         default:         hit = 1'b0;
      endcase
      return hit;
   endfunction

   assign ctrl  = useq_rom(step_ff);
   assign hit_a = cond_hit(ctrl.cond_a, req_valid, flags);
   assign hit_b = cond_hit(ctrl.cond_b, req_valid, flags);

   always_comb begin
      if (hit_a) begin
         step_in = ctrl.target_a;
      end else if (hit_b) begin
         step_in = ctrl.target_b;
      end else begin
         step_in = ctrl.next_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ hw/rtl/ptw_walk.sv @@
// ----------------------------------------------------------------------------
// ptw_walk
// Walk datapath: frame cursor, per-process counters, entry updates, result.
// ----------------------------------------------------------------------------
module ptw_walk (
   input  logic                              clock,
   input  logic                              reset,
   input  ptw_pkg::useq_word_type            ctrl,
   output ptw_pkg::walk_flags_type           flags,
   input  logic                              req_valid,
   input  logic [ptw_pkg::PROC_W-1:0]        req_process_index,
   input  logic [ptw_pkg::PAGE_W-1:0]        req_virtual_page,
   input  logic                              csr_wr_en,
   input  logic [ptw_pkg::COUNT_W-1:0]       csr_wr_data,
   input  logic [ptw_pkg::ENTRY_W-1:0]       rd_data,
   output logic [ptw_pkg::ADDR_W-1:0]        rd_addr,
   output logic                              wr_en,
   output logic [ptw_pkg::ADDR_W-1:0]        wr_addr,
   output logic [ptw_pkg::ENTRY_W-1:0]       wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [1:0]                        rsp_faults,
   output logic [ptw_pkg::FRAME_W-1:0]       rsp_table_frame,
   output logic [ptw_pkg::FRAME_W-1:0]       rsp_data_frame,
   output logic [ptw_pkg::REFS_W-1:0]        rsp_entry_refs,
   output logic [ptw_pkg::CURSOR_W-1:0]      rsp_process_frames,
   output logic [ptw_pkg::STAT_W-1:0]        rsp_process_faults,
   output logic [ptw_pkg::STAT_W-1:0]        rsp_process_refs
);
   import ptw_pkg::*;

   // configuration and global state
   logic [COUNT_W-1:0]  count_ff;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic                halted_ff, halted_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;

   // current access
   logic [PROC_W-1:0]   p_ff, p_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [1:0]          status_ff, status_in;
   logic [1:0]          faults_ff, faults_in;
   logic [FRAME_W-1:0]  tframe_ff, tframe_in;
   logic [FRAME_W-1:0]  dframe_ff, dframe_in;
   logic [REFS_W-1:0]   refs_ff, refs_in;

   // per-process counters
   logic [FRAME_W-1:0]  frames_ff [PROCESSES];
   logic [STAT_W-1:0]   fcnt_ff   [PROCESSES];
   logic [STAT_W-1:0]   rcnt_ff   [PROCESSES];
   logic [FRAME_W-1:0]  frames_sel, frames_in;
   logic [STAT_W-1:0]   fcnt_sel, fcnt_in;
   logic [STAT_W-1:0]   rcnt_sel, rcnt_in;
   logic                note_fault;
   logic                ref_inc;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff;
   logic [1:0]          rsp_faults_ff;
   logic [FRAME_W-1:0]  rsp_table_frame_ff;
   logic [FRAME_W-1:0]  rsp_data_frame_ff;
   logic [REFS_W-1:0]   rsp_entry_refs_ff;
   logic [CURSOR_W-1:0] rsp_process_frames_ff;
   logic [STAT_W-1:0]   rsp_process_faults_ff;
   logic [STAT_W-1:0]   rsp_process_refs_ff;
   logic                out_load;

   logic                e_valid;
   logic [FRAME_W-1:0]  e_frame;
   logic [REFS_W-1:0]   e_refs;
   logic [COUNT_W-1:0]  eff_count;
   logic [COUNT_W-1:0]  eff_cfg;
   logic                proc_ok;
   logic                oom;
   logic                bump;
   logic [FRAME_W-1:0]  leaf_frame;
   logic [REFS_W-1:0]   leaf_refs;
   logic [ADDR_W-1:0]   l1_addr;
   logic [ADDR_W-1:0]   l2_addr;
   logic                accept;

   assign e_valid = rd_data[0];
   assign e_frame = rd_data[FRAME_W:1];
   assign e_refs  = rd_data[ENTRY_W-1 -: REFS_W];

   assign eff_count = (count_ff > COUNT_W'(PROCESSES)) ? COUNT_W'(PROCESSES) : count_ff;
   assign eff_cfg   = (csr_wr_data > COUNT_W'(PROCESSES)) ? COUNT_W'(PROCESSES)
                                                          : csr_wr_data;
   assign proc_ok   = COUNT_W'(p_ff) < eff_count;
   assign oom       = cursor_ff >= CURSOR_W'(FRAMES);

   assign l1_addr = {FRAME_W'(p_ff), page_ff[IDX_W +: IDX_W]};
   assign l2_addr = {tframe_ff, page_ff[IDX_W-1:0]};

   assign frames_sel = frames_ff[p_ff];
   assign fcnt_sel   = fcnt_ff[p_ff];
   assign rcnt_sel   = rcnt_ff[p_ff];
   assign frames_in  = frames_sel + FRAME_W'(1);
   assign fcnt_in    = (fcnt_sel == '1) ? fcnt_sel : fcnt_sel + STAT_W'(1);
   assign rcnt_in    = (rcnt_sel == '1) ? rcnt_sel : rcnt_sel + STAT_W'(1);

   assign accept = req_valid && ctrl.req_ready;

   // walk ends early when halted, the index is bad or no frame is left
   assign flags.stop       = halted_ff || !proc_ok || (!e_valid && oom);
   assign flags.fault      = !flags.stop && !e_valid;
   assign flags.out_free   = !rsp_valid_ff || rsp_ready;
   assign flags.clear_done = (clr_addr_ff == '1);

   always_comb begin
      case (ctrl.rd_sel)
         RD_REQ:   rd_addr = {FRAME_W'(req_process_index),
                              req_virtual_page[IDX_W +: IDX_W]};
         RD_ENTRY: rd_addr = {e_frame, page_ff[IDX_W-1:0]};
         RD_TABLE: rd_addr = l2_addr;
         default:  rd_addr = l2_addr;
      endcase
   end

   always_comb begin
      p_in        = p_ff;
      page_in     = page_ff;
      status_in   = status_ff;
      faults_in   = faults_ff;
      tframe_in   = tframe_ff;
      dframe_in   = dframe_ff;
      refs_in     = refs_ff;
      halted_in   = halted_ff;
      clr_addr_in = clr_addr_ff;
      wr_en       = 1'b0;
      wr_addr     = clr_addr_ff;
      wr_data     = '0;
      bump        = 1'b0;
      note_fault  = 1'b0;
      ref_inc     = 1'b0;
      out_load    = 1'b0;
      leaf_frame  = e_valid ? e_frame : cursor_ff[FRAME_W-1:0];
      leaf_refs   = e_refs + REFS_W'(1);

      if (accept) begin
         p_in    = req_process_index;
         page_in = req_virtual_page;
      end

      unique case (ctrl.op)
         OP_NONE: begin
         end
         OP_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         OP_LEVEL1: begin
            faults_in = '0;
            dframe_in = '0;
            refs_in   = '0;
            tframe_in = e_frame;
            status_in = STATUS_OK;
            if (halted_ff) begin
               status_in = STATUS_OOM;
               tframe_in = '0;
            end else if (!proc_ok) begin
               status_in = STATUS_BAD;
               tframe_in = '0;
            end else if (!e_valid) begin
               if (oom) begin
                  halted_in = 1'b1;
                  status_in = STATUS_OOM;
                  tframe_in = '0;
               end else begin
                  // allocate the second-level table
                  wr_en      = 1'b1;
                  wr_addr    = l1_addr;
                  wr_data    = {e_refs, cursor_ff[FRAME_W-1:0], 1'b1};
                  tframe_in  = cursor_ff[FRAME_W-1:0];
                  bump       = 1'b1;
                  note_fault = 1'b1;
                  faults_in  = 2'd1;
               end
            end
         end
         OP_LEVEL2: begin
            if (!e_valid && oom) begin
               halted_in = 1'b1;
               status_in = STATUS_OOM;
            end else begin
               if (!e_valid) begin
                  bump       = 1'b1;
                  note_fault = 1'b1;
                  faults_in  = faults_ff + 2'd1;
               end
               wr_en     = 1'b1;
               wr_addr   = l2_addr;
               wr_data   = {leaf_refs, leaf_frame, 1'b1};
               ref_inc   = 1'b1;
               dframe_in = leaf_frame;
               refs_in   = leaf_refs;
               status_in = STATUS_OK;
            end
         end
         OP_EMIT: begin
            out_load = flags.out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cursor_in = cursor_ff;
      if (bump) begin
         cursor_in = cursor_ff + CURSOR_W'(1);
      end else if (csr_wr_en && cursor_ff < CURSOR_W'(eff_cfg)) begin
         cursor_in = CURSOR_W'(eff_cfg);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_W'(1);
         cursor_ff    <= CURSOR_W'(1);
         halted_ff    <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PROCESSES; i++) begin
            frames_ff[i] <= '0;
            fcnt_ff[i]   <= '0;
            rcnt_ff[i]   <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         cursor_ff    <= cursor_in;
         halted_ff    <= halted_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (note_fault) begin
            frames_ff[p_ff] <= frames_in;
            fcnt_ff[p_ff]   <= fcnt_in;
         end
         if (ref_inc) begin
            rcnt_ff[p_ff] <= rcnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      page_ff   <= page_in;
      status_ff <= status_in;
      faults_ff <= faults_in;
      tframe_ff <= tframe_in;
      dframe_ff <= dframe_in;
      refs_ff   <= refs_in;
      if (out_load) begin
         rsp_status_ff      <= status_ff;
         rsp_faults_ff      <= faults_ff;
         rsp_table_frame_ff <= tframe_ff;
         rsp_data_frame_ff  <= dframe_ff;
         rsp_entry_refs_ff  <= refs_ff;
         // a bad index shows no process figures
         if (proc_ok) begin
            rsp_process_frames_ff <= CURSOR_W'(frames_sel) + CURSOR_W'(1);
            rsp_process_faults_ff <= fcnt_sel;
            rsp_process_refs_ff   <= rcnt_sel;
         end else begin
            rsp_process_frames_ff <= '0;
            rsp_process_faults_ff <= '0;
            rsp_process_refs_ff   <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_faults         = rsp_faults_ff;
   assign rsp_table_frame    = rsp_table_frame_ff;
   assign rsp_data_frame     = rsp_data_frame_ff;
   assign rsp_entry_refs     = rsp_entry_refs_ff;
   assign rsp_process_frames = rsp_process_frames_ff;
   assign rsp_process_faults = rsp_process_faults_ff;
   assign rsp_process_refs   = rsp_process_refs_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(halted_ff)) |-> halted_ff)
      else $error("halt flag dropped");

   a_cursor_rises: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (cursor_ff >= $past(cursor_ff)))
      else $error("frame cursor moved back");

   a_write_below_cursor: assert property (@(posedge clock) disable iff (reset)
      (wr_en && ctrl.op != OP_CLEAR) |->
         (CURSOR_W'(wr_addr[ADDR_W-1 -: FRAME_W]) < cursor_ff))
      else $error("entry written in a frame not yet handed out");

   a_bad_index_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_BAD) |->
         (rsp_process_frames_ff == '0 && rsp_data_frame_ff == '0
          && rsp_faults_ff == '0))
      else $error("bad-index beat carries walk data");

endmodule

@@ tb/two_level_page_walk_demand_alloc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_page_walk_demand_alloc_checker
// Watches the request, response and CSR ports of the page walker. Keeps its
// own copy of the page tables, frame cursor and per-process counters. For
// every accepted request it predicts the response and compares it, field by
// field, with the next response beat.
// ----------------------------------------------------------------------------
module two_level_page_walk_demand_alloc_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [ptw_pkg::PROC_W-1:0]   req_process_index,
   input  logic [ptw_pkg::PAGE_W-1:0]   req_virtual_page,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [1:0]                   rsp_status,
   input  logic [1:0]                   rsp_faults,
   input  logic [ptw_pkg::FRAME_W-1:0]  rsp_table_frame,
   input  logic [ptw_pkg::FRAME_W-1:0]  rsp_data_frame,
   input  logic [ptw_pkg::REFS_W-1:0]   rsp_entry_refs,
   input  logic [ptw_pkg::CURSOR_W-1:0] rsp_process_frames,
   input  logic [ptw_pkg::STAT_W-1:0]   rsp_process_faults,
   input  logic [ptw_pkg::STAT_W-1:0]   rsp_process_refs,
   input  logic                         csr_wr_en,
   input  logic [ptw_pkg::COUNT_W-1:0]  csr_wr_data,
   output int                           expected_left,
   output int                           mismatch_total,
   output int                           ok_beats,
   output int                           oom_beats,
   output int                           bad_beats
);
   import ptw_pkg::*;

   typedef struct packed {
      logic [1:0]          status;
      logic [1:0]          faults;
      logic [FRAME_W-1:0]  table_frame;
      logic [FRAME_W-1:0]  data_frame;
      logic [REFS_W-1:0]   entry_refs;
      logic [CURSOR_W-1:0] proc_frames;
      logic [STAT_W-1:0]   proc_faults;
      logic [STAT_W-1:0]   proc_refs;
   } walk_result_type;

   // entry layout: refs in [16:9], frame in [8:1], valid in [0]
   logic [ENTRY_W-1:0]  entry_mem [STORE_DEPTH];
   logic [CURSOR_W-1:0] free_cursor;
   logic [FRAME_W-1:0]  held_frames [PROCESSES];
   logic [STAT_W-1:0]   fault_tally [PROCESSES];
   logic [STAT_W-1:0]   ref_tally [PROCESSES];
   logic                walker_halted;
   logic [COUNT_W-1:0]  count_reg;

   walk_result_type pending_walks [$];
   walk_result_type want_walk;
   int              miss_count = 0;
   int              beat_no = 0;

   assign mismatch_total = miss_count;

   function automatic logic [COUNT_W-1:0] live_count();
      return (count_reg > COUNT_W'(PROCESSES)) ? COUNT_W'(PROCESSES) : count_reg;
   endfunction

   function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic void charge_fault(input logic [PROC_W-1:0] proc);
      held_frames[proc] = held_frames[proc] + 1'b1;
      fault_tally[proc] = sat_inc(fault_tally[proc]);
   endfunction

   function automatic void fill_stats(inout walk_result_type r,
                                      input logic [PROC_W-1:0] proc);
      r.proc_frames = {1'b0, held_frames[proc]} + 1'b1;
      r.proc_faults = fault_tally[proc];
      r.proc_refs   = ref_tally[proc];
   endfunction

   function automatic walk_result_type predict_walk(input logic [PROC_W-1:0] proc,
                                                    input logic [PAGE_W-1:0] vpage);
      walk_result_type    r;
      logic               known;
      logic [ADDR_W-1:0]  top_addr;
      logic [ADDR_W-1:0]  leaf_addr;
      logic [ENTRY_W-1:0] top_entry;
      logic [ENTRY_W-1:0] leaf_entry;
      logic [FRAME_W-1:0] tbl_frame;
      logic [REFS_W-1:0]  refs;
      r     = '0;
      known = {1'b0, proc} < live_count();
      if (walker_halted) begin
         r.status = STATUS_OOM;
         if (known) fill_stats(r, proc);
         return r;
      end
      if (!known) begin
         r.status = STATUS_BAD;
         return r;
      end
      // first level: frame p holds process p's directory
      top_addr  = ADDR_W'({proc, vpage[5:3]});
      top_entry = entry_mem[top_addr];
      if (!top_entry[0]) begin
         if (free_cursor >= CURSOR_W'(FRAMES)) begin
            walker_halted = 1'b1;
            r.status = STATUS_OOM;
            fill_stats(r, proc);
            return r;
         end
         top_entry = {top_entry[ENTRY_W-1:FRAME_W+1], free_cursor[FRAME_W-1:0], 1'b1};
         entry_mem[top_addr] = top_entry;
         free_cursor = free_cursor + 1'b1;
         charge_fault(proc);
         r.faults = r.faults + 1'b1;
      end
      tbl_frame = top_entry[FRAME_W:1];
      // second level; read after the directory write, the two may alias
      leaf_addr  = {tbl_frame, vpage[2:0]};
      leaf_entry = entry_mem[leaf_addr];
      if (!leaf_entry[0]) begin
         if (free_cursor >= CURSOR_W'(FRAMES)) begin
            walker_halted = 1'b1;
            r.status      = STATUS_OOM;
            r.table_frame = tbl_frame;
            fill_stats(r, proc);
            return r;
         end
         leaf_entry = {leaf_entry[ENTRY_W-1:FRAME_W+1], free_cursor[FRAME_W-1:0], 1'b1};
         free_cursor = free_cursor + 1'b1;
         charge_fault(proc);
         r.faults = r.faults + 1'b1;
      end
      refs = leaf_entry[ENTRY_W-1:FRAME_W+1] + 1'b1;
      entry_mem[leaf_addr] = {refs, leaf_entry[FRAME_W:0]};
      ref_tally[proc] = sat_inc(ref_tally[proc]);
      r.status      = STATUS_OK;
      r.table_frame = tbl_frame;
      r.data_frame  = leaf_entry[FRAME_W:1];
      r.entry_refs  = refs;
      fill_stats(r, proc);
      return r;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         if (miss_count < 10)
            $display("%0t: beat %0d %s mismatch: expected %0d, got %0d",
                     $realtime, beat_no, field, want, got);
         miss_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) entry_mem[i] = '0;
         for (int i = 0; i < PROCESSES; i++) begin
            held_frames[i] = '0;
            fault_tally[i] = '0;
            ref_tally[i]   = '0;
         end
         walker_halted = 1'b0;
         count_reg     = COUNT_W'(1);
         free_cursor   = CURSOR_W'(live_count());
         ok_beats      = 0;
         oom_beats     = 0;
         bad_beats     = 0;
         pending_walks.delete();
      end else begin
         // retire first: a request taken on this edge cannot answer yet
         if (rsp_valid && rsp_ready) begin
            beat_no++;
            case (rsp_status)
               STATUS_OK:  ok_beats++;
               STATUS_OOM: oom_beats++;
               default:    bad_beats++;
            endcase
            if (pending_walks.size() == 0) begin
               if (miss_count < 10)
                  $display("%0t: beat %0d arrived with no access outstanding",
                           $realtime, beat_no);
               miss_count++;
            end else begin
               want_walk = pending_walks.pop_front();
               check_field("status", want_walk.status, rsp_status);
               check_field("faults", want_walk.faults, rsp_faults);
               check_field("table_frame", want_walk.table_frame, rsp_table_frame);
               check_field("data_frame", want_walk.data_frame, rsp_data_frame);
               check_field("entry_refs", want_walk.entry_refs, rsp_entry_refs);
               check_field("process_frames", want_walk.proc_frames, rsp_process_frames);
               check_field("process_faults", want_walk.proc_faults, rsp_process_faults);
               check_field("process_refs", want_walk.proc_refs, rsp_process_refs);
            end
         end
         if (req_valid && req_ready)
            pending_walks.push_back(predict_walk(req_process_index, req_virtual_page));
         if (csr_wr_en) begin
            count_reg = csr_wr_data;
            // raise the cursor past the new directories, never lower it
            if (free_cursor < CURSOR_W'(live_count())) free_cursor = CURSOR_W'(live_count());
         end
      end
      expected_left <= pending_walks.size();
   end

endmodule

@@ tb/two_level_page_walk_demand_alloc_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_page_walk_demand_alloc_tb
// Drives page accesses into the walker through a bursty sender while the
// response side stalls on its own pattern. Runs directed accesses, a spread
// working set, a hot leaf that wraps its reference count and a sweep that
// exhausts the frame pool, across several process counts. The checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module two_level_page_walk_demand_alloc_tb;
   import ptw_pkg::*;

   localparam int LIMIT_CYCLES = 200_000;
   localparam logic [PAGE_W-1:0] WORKING_PAGES [4] = '{6'd0, 6'd63, 6'd21, 6'd42};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PROC_W-1:0]     req_process_index = '0;
   logic [PAGE_W-1:0]     req_virtual_page = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_status;
   logic [1:0]            rsp_faults;
   logic [FRAME_W-1:0]    rsp_table_frame;
   logic [FRAME_W-1:0]    rsp_data_frame;
   logic [REFS_W-1:0]     rsp_entry_refs;
   logic [CURSOR_W-1:0]   rsp_process_frames;
   logic [STAT_W-1:0]     rsp_process_faults;
   logic [STAT_W-1:0]     rsp_process_refs;
   logic                  csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]    csr_wr_data = '0;

   int expected_left;
   int mismatch_total;
   int ok_beats;
   int oom_beats;
   int bad_beats;

   int unsigned burst_left = 0;
   int unsigned accesses_sent = 0;
   int unsigned cycle_count = 0;
   logic [COUNT_W-1:0] live_procs;
   logic [PROC_W-1:0]  hot_proc;
   logic [PAGE_W-1:0]  hot_page;

   always #5 clock = ~clock;

   two_level_page_walk_demand_alloc u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_process_index  (req_process_index),
      .req_virtual_page   (req_virtual_page),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_faults         (rsp_faults),
      .rsp_table_frame    (rsp_table_frame),
      .rsp_data_frame     (rsp_data_frame),
      .rsp_entry_refs     (rsp_entry_refs),
      .rsp_process_frames (rsp_process_frames),
      .rsp_process_faults (rsp_process_faults),
      .rsp_process_refs   (rsp_process_refs),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   two_level_page_walk_demand_alloc_checker u_walk_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_process_index  (req_process_index),
      .req_virtual_page   (req_virtual_page),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_faults         (rsp_faults),
      .rsp_table_frame    (rsp_table_frame),
      .rsp_data_frame     (rsp_data_frame),
      .rsp_entry_refs     (rsp_entry_refs),
      .rsp_process_frames (rsp_process_frames),
      .rsp_process_faults (rsp_process_faults),
      .rsp_process_refs   (rsp_process_refs),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .expected_left      (expected_left),
      .mismatch_total     (mismatch_total),
      .ok_beats           (ok_beats),
      .oom_beats          (oom_beats),
      .bad_beats          (bad_beats)
   );

   // response side: mostly ready, short stalls, the odd long open stretch
   always @(posedge clock) begin : rsp_pace
      int unsigned hold_cnt;
      if (hold_cnt == 0) begin
         if ($urandom_range(0, 15) == 0) begin
            rsp_ready <= 1'b1;
            hold_cnt = $urandom_range(40, 80);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            hold_cnt = $urandom_range(1, 6);
         end else begin
            rsp_ready <= 1'b1;
            hold_cnt = $urandom_range(1, 12);
         end
      end else begin
         hold_cnt--;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("two_level_page_walk_demand_alloc_tb: FAIL");
         $finish;
      end
   end

   // present one access; valid stays up across a burst, drops for a gap
   task automatic send_access(input logic [PROC_W-1:0] proc, input logic [PAGE_W-1:0] vpage);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      req_valid         <= 1'b1;
      req_process_index <= proc;
      req_virtual_page  <= vpage;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      accesses_sent++;
   endtask

   // hold the sender until every outstanding response is back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      live_procs = (value > COUNT_W'(PROCESSES)) ? COUNT_W'(PROCESSES) : value;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // wait out the store sweep
      @(posedge clock);
      while (!req_ready) @(posedge clock);

      // reset count of one: faults on both levels, hits, bad indices
      send_access(4'd0, 6'd0);
      send_access(4'd0, 6'd0);
      send_access(4'd0, 6'd63);
      send_access(4'd1, 6'd5);
      send_access(4'd15, 6'd42);
      send_access(4'd0, 6'd7);
      send_access(4'd0, 6'd56);
      drain();
      write_count(5'd0);
      send_access(4'd0, 6'd1);
      send_access(4'd3, 6'd62);
      drain();
      // raise above the cursor: new directories land on frames already in use
      write_count(5'd31);
      send_access(4'd1, 6'd0);
      send_access(4'd1, 6'd56);
      send_access(4'd2, 6'd8);
      send_access(4'd15, 6'd21);
      send_access(4'd5, 6'd63);
      send_access(4'd0, 6'd0);

      // spread working set across all processes
      for (int i = 0; i < 100; i++) begin
         if (i == 50) drain();
         if ($urandom_range(0, 9) == 0)
            send_access(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
         else
            send_access(4'($urandom_range(0, 15)), WORKING_PAGES[$urandom_range(0, 3)]);
      end

      // hammer one leaf until its reference count wraps
      drain();
      write_count(5'($urandom_range(2, 15)));
      hot_proc = 4'($urandom_range(0, live_procs - 1));
      hot_page = WORKING_PAGES[$urandom_range(0, 3)];
      for (int i = 0; i < 290; i++) begin
         if ($urandom_range(0, 99) < 92)
            send_access(hot_proc, hot_page);
         else
            send_access(4'($urandom_range(0, 15)), WORKING_PAGES[$urandom_range(0, 3)]);
      end

      // fresh pages everywhere: runs the pool dry and halts the walker
      drain();
      write_count(5'd16);
      for (int i = 0; i < 180; i++)
         send_access(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));

      drain();
      write_count(5'd1);
      for (int i = 0; i < 30; i++)
         send_access(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));

      drain();
      repeat (20) @(posedge clock);
      $display("%0d accesses over six process-count settings, with a halt on exhaustion;",
               accesses_sent);
      $display("responses: %0d translated, %0d out of memory, %0d bad index",
               ok_beats, oom_beats, bad_beats);
      if (mismatch_total == 0 && expected_left == 0)
         $display("two_level_page_walk_demand_alloc_tb: PASS");
      else
         $display("two_level_page_walk_demand_alloc_tb: FAIL");
      $finish;
   end

endmodule
